// File: rtl/jsfe_pkg.sv
// -----------------------------------------------------------------------------
// jsfe_pkg
// shared types and constants of the json string field extractor
// -----------------------------------------------------------------------------
package jsfe_pkg;

    // key limits
    localparam int KEY_MAX_DEF = 14;
    localparam int KEY_BYTES   = 14;
    localparam int KLEN_W      = 4;
    localparam int LEN_W       = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_CONTINUE  = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // characters
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_body;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       has_byte;
        logic [1:0] status;
    } result_t;

    typedef logic [KEY_BYTES-1:0][7:0] key_t;

endpackage

// File: rtl/jsfe_key_match.sv
// -----------------------------------------------------------------------------
// jsfe_key_match
// parallel compare of the byte window against the quoted key
// -----------------------------------------------------------------------------
module jsfe_key_match #(
    parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF,
    parameter int WIN     = KEY_MAX + 2,
    parameter int CNT_W   = $clog2(WIN + 1)
) (
    input  logic [WIN-1:0][7:0]           window,
    input  logic [CNT_W-1:0]              count,
    input  logic [jsfe_pkg::KLEN_W-1:0]   key_length,
    input  jsfe_pkg::key_t                key,
    output logic                          match
);
    import jsfe_pkg::*;

    logic [KLEN_W-1:0] klen;
    logic [LEN_W-1:0]  len;
    logic [WIN-1:0]    pos_ok;

    assign klen = (key_length > KLEN_W'(KEY_MAX)) ? KLEN_W'(KEY_MAX) : key_length;
    assign len  = LEN_W'(klen) + LEN_W'(2);

    // newest byte at position zero, opening quote at position len-1
    always_comb
    begin
        logic [LEN_W-1:0]  kk;
        logic [KLEN_W-1:0] idx;
        logic [7:0]        want;
        for (int k = 0; k < WIN; k++)
        begin
            kk  = LEN_W'(k);
            idx = klen - kk[KLEN_W-1:0];
            if (kk == '0 || kk == len - LEN_W'(1))
                want = CH_QUOTE;
            else if (idx < KLEN_W'(KEY_BYTES))
                want = key[idx];
            else
                want = 8'h00;
            pos_ok[k] = (kk >= len) || (window[k] == want);
        end
    end

    assign match = (LEN_W'(count) >= len) && (&pos_ok);

endmodule

// File: rtl/jsfe_parse.sv
// -----------------------------------------------------------------------------
// jsfe_parse
// byte window, phase tracking and value unescaping, one byte per transfer
// -----------------------------------------------------------------------------
module jsfe_parse #(
    parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  jsfe_pkg::in_item_t            item,
    input  logic [jsfe_pkg::KLEN_W-1:0]   key_length,
    input  jsfe_pkg::key_t                key,
    output logic                          res_valid,
    output jsfe_pkg::result_t             res
);
    import jsfe_pkg::*;

    localparam int WIN   = KEY_MAX + 2;
    localparam int CNT_W = $clog2(WIN + 1);

    typedef enum logic [5:0] {
        PH_SEARCH = 6'b000001,
        PH_COLON  = 6'b000010,
        PH_SPACE  = 6'b000100,
        PH_VALUE  = 6'b001000,
        PH_ESCAPE = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    phase_t              phase_reg, phase_next, phase_step;
    logic [WIN-1:0][7:0] win_reg, win_shift;
    logic [CNT_W-1:0]    count_reg, count_inc;
    logic                match;
    logic [7:0]          c;
    logic                emit;
    result_t             step_res;

    assign c         = item.in_byte;
    assign win_shift = {win_reg[WIN-2:0], c};
    assign count_inc = (count_reg == CNT_W'(WIN)) ? count_reg : count_reg + CNT_W'(1);

    jsfe_key_match #(
        .KEY_MAX (KEY_MAX)
    ) u_match (
        .window     (win_shift),
        .count      (count_inc),
        .key_length (key_length),
        .key        (key),
        .match      (match)
    );

    always_comb
    begin
        phase_step = phase_reg;
        emit       = 1'b0;
        step_res   = '{value_byte: 8'h00, has_byte: 1'b0, status: STATUS_CONTINUE};
        case (phase_reg)
            PH_SEARCH:
            begin
                if (match)
                    phase_step = PH_COLON;
            end
            PH_COLON:
            begin
                if (c == CH_COLON)
                    phase_step = PH_SPACE;
            end
            PH_SPACE:
            begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
                    phase_step = PH_SPACE;
                else if (c == CH_QUOTE)
                    phase_step = PH_VALUE;
                else
                begin
                    emit            = 1'b1;
                    step_res.status = STATUS_NOT_FOUND;
                    phase_step      = PH_DONE;
                end
            end
            PH_VALUE:
            begin
                if (c == CH_BACKSLASH)
                    phase_step = PH_ESCAPE;
                else if (c == CH_QUOTE)
                begin
                    emit            = 1'b1;
                    step_res.status = STATUS_COMPLETE;
                    phase_step      = PH_DONE;
                end
                else
                begin
                    emit                = 1'b1;
                    step_res.value_byte = c;
                    step_res.has_byte   = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (c == CH_N)
                    step_res.value_byte = CH_LF;
                else if (c == CH_R)
                    step_res.value_byte = CH_CR;
                else if (c == CH_T)
                    step_res.value_byte = CH_TAB;
                else
                    step_res.value_byte = c;
                emit              = 1'b1;
                step_res.has_byte = 1'b1;
                phase_step        = PH_VALUE;
            end
            PH_DONE:
            begin
                phase_step = PH_DONE;
            end
            default:
            begin
                phase_step = PH_SEARCH;
            end
        endcase

        // body ends without a verdict
        res_valid = accept && emit;
        res       = step_res;
        if (item.end_of_body && phase_step != PH_DONE)
        begin
            res_valid = accept;
            res       = '{value_byte: 8'h00, has_byte: 1'b0, status: STATUS_NOT_FOUND};
        end

        phase_next = item.end_of_body ? PH_SEARCH : phase_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            if (item.end_of_body)
                count_reg <= '0;
            else if (phase_reg == PH_SEARCH)
                count_reg <= count_inc;
        end
    end

    // window contents beyond the count are never compared
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_SEARCH)
            win_reg <= win_shift;
    end

endmodule

// File: rtl/jsfe_out_buf.sv
// -----------------------------------------------------------------------------
// jsfe_out_buf
// result register with one skid entry
// -----------------------------------------------------------------------------
module jsfe_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsfe_pkg::result_t  push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_stall,
    output jsfe_pkg::result_t  out_data
);
    import jsfe_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (out_valid_reg && skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// File: rtl/json_string_field_extractor.sv
// a result is registered in the result register, or in its skid entry while that register is held, before it is output
// throughput: one body byte per cycle while in_stall is low; the key window compare is parallel logic
// input stalls only while both the result register and its skid entry are occupied
// reset (rst_n low, asynchronous): phase to key search, window count and key registers cleared
// -----------------------------------------------------------------------------
// json_string_field_extractor
// finds a quoted key in a byte stream and streams out its unescaped string value
// -----------------------------------------------------------------------------
module json_string_field_extractor #(
    parameter int KEY_MAX = jsfe_pkg::KEY_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // body byte channel
    input  logic               in_valid,
    output logic               in_stall,
    input  jsfe_pkg::in_item_t in_data,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output jsfe_pkg::result_t  out_data,
    // configuration writes
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import jsfe_pkg::*;

    logic [KLEN_W-1:0] key_length_reg;
    logic [63:0]       key_low_reg;
    logic [47:0]       key_high_reg;
    key_t              key;

    logic              accept;
    logic              res_valid;
    result_t           res;
    logic              buf_full;

    // key bytes as one array, byte zero in the low bits of key_low_reg
    assign key = {key_high_reg, key_low_reg};

    // configuration registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_KEY_LENGTH: key_length_reg <= cfg_data[KLEN_W-1:0];
                CFG_KEY_LOW:    key_low_reg    <= cfg_data;
                CFG_KEY_HIGH:   key_high_reg   <= cfg_data[47:0];
                default:        ;
            endcase
        end
    end

    // a transfer is taken whenever the skid entry is free
    assign in_stall = buf_full;
    assign accept   = in_valid && !in_stall;

    // window, phase and unescape logic, one transfer per cycle while the input is not stalled
    jsfe_parse #(
        .KEY_MAX (KEY_MAX)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (in_data),
        .key_length (key_length_reg),
        .key        (key),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register plus skid entry decouple the two channels
    jsfe_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: tb/sv/json_string_field_extractor_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// json_string_field_extractor_checker
// watches the byte, result and configuration ports, keeps its own copy of the
// key search and value unescaping, and compares every result transfer in order
// -----------------------------------------------------------------------------
module json_string_field_extractor_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  jsfe_pkg::in_item_t in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  jsfe_pkg::result_t  out_data,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 failures,
    output int                 pending
);
    import jsfe_pkg::*;

    localparam int WINDOW = 16;

    typedef enum logic [2:0] {
        FIND_KEY,
        FIND_COLON,
        SKIP_BLANKS,
        TAKE_VALUE,
        TAKE_ESCAPED,
        VERDICT_OUT
    } scan_phase_t;

    logic [3:0]  key_len;
    logic [63:0] key_low;
    logic [47:0] key_high;

    logic [7:0]  recent [WINDOW];
    logic [4:0]  bytes_seen;
    scan_phase_t phase;

    result_t     due_results [$];
    int          fail_count = 0;
    int          due_count = 0;

    assign failures = fail_count;
    assign pending  = due_count;

    function automatic void clear_scan();
        for (int i = 0; i < WINDOW; i++)
            recent[i] = 8'h00;
        bytes_seen = '0;
        phase      = FIND_KEY;
    endfunction

    // quoted key ends at the newest window entry
    function automatic bit key_in_window();
        int         klen;
        int         span;
        int         j;
        logic [7:0] want;
        klen = (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len);
        span = klen + 2;
        if (bytes_seen < span)
            return 1'b0;
        for (int k = 0; k < span; k++)
        begin
            j = span - 1 - k;
            if (j == 0 || j == span - 1)
                want = CH_QUOTE;
            else if (j - 1 < 8)
                want = key_low[8*(j-1) +: 8];
            else
                want = key_high[8*(j-9) +: 8];
            if (recent[k] != want)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic scan_body_byte(input in_item_t item);
        result_t    r;
        logic       emit;
        logic [7:0] c;
        c    = item.in_byte;
        emit = 1'b0;
        r    = '0;
        case (phase)
            FIND_KEY:
            begin
                for (int i = WINDOW - 1; i > 0; i--)
                    recent[i] = recent[i-1];
                recent[0] = c;
                if (bytes_seen < WINDOW)
                    bytes_seen++;
                if (key_in_window())
                    phase = FIND_COLON;
            end
            FIND_COLON:
            begin
                if (c == CH_COLON)
                    phase = SKIP_BLANKS;
            end
            SKIP_BLANKS:
            begin
                if (c == CH_QUOTE)
                    phase = TAKE_VALUE;
                else if (!(c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR))
                begin
                    emit     = 1'b1;
                    r.status = STATUS_NOT_FOUND;
                    phase    = VERDICT_OUT;
                end
            end
            TAKE_VALUE:
            begin
                if (c == CH_BACKSLASH)
                    phase = TAKE_ESCAPED;
                else if (c == CH_QUOTE)
                begin
                    emit     = 1'b1;
                    r.status = STATUS_COMPLETE;
                    phase    = VERDICT_OUT;
                end
                else
                begin
                    emit         = 1'b1;
                    r.value_byte = c;
                    r.has_byte   = 1'b1;
                    r.status     = STATUS_CONTINUE;
                end
            end
            TAKE_ESCAPED:
            begin
                case (c)
                    CH_N:    r.value_byte = CH_LF;
                    CH_R:    r.value_byte = CH_CR;
                    CH_T:    r.value_byte = CH_TAB;
                    default: r.value_byte = c;
                endcase
                emit       = 1'b1;
                r.has_byte = 1'b1;
                r.status   = STATUS_CONTINUE;
                phase      = TAKE_VALUE;
            end
            default:
            begin
            end
        endcase
        // body ended without a verdict
        if (item.end_of_body)
        begin
            if (phase != VERDICT_OUT)
            begin
                emit     = 1'b1;
                r        = '0;
                r.status = STATUS_NOT_FOUND;
            end
            clear_scan();
        end
        if (emit)
            due_results = {due_results, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len  = '0;
            key_low  = '0;
            key_high = '0;
            clear_scan();
            due_results.delete();
            due_count = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_KEY_LENGTH: key_len  = cfg_data[3:0];
                    CFG_KEY_LOW:    key_low  = cfg_data;
                    CFG_KEY_HIGH:   key_high = cfg_data[47:0];
                    default:        ;
                endcase
            end
            // compare before this edge's byte adds its own expectation
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("unexpected result: value_byte %02h has_byte %0b status %0d",
                           out_data.value_byte, out_data.has_byte, out_data.status);
                    fail_count++;
                end
                else
                begin
                    result_t exp;
                    exp = due_results.pop_front();
                    if (out_data.value_byte !== exp.value_byte)
                    begin
                        $error("value_byte: expected %02h, actual %02h",
                               exp.value_byte, out_data.value_byte);
                        fail_count++;
                    end
                    if (out_data.has_byte !== exp.has_byte)
                    begin
                        $error("has_byte: expected %0b, actual %0b",
                               exp.has_byte, out_data.has_byte);
                        fail_count++;
                    end
                    if (out_data.status !== exp.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               exp.status, out_data.status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                scan_body_byte(in_data);
            due_count = due_results.size();
        end
    end

endmodule

// File: tb/sv/json_string_field_extractor_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// json_string_field_extractor_tb
// drives message bodies through the extractor under several key settings,
// with random gaps and stalls on both channels and one long result hold-off;
// the checker beside the block predicts and compares every result transfer
// -----------------------------------------------------------------------------
module json_string_field_extractor_tb;
    import jsfe_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;  // far above the slowest legal run
    localparam int TARGET_BYTES   = 1500;
    localparam int BODIES_PER_KEY = 6;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 4;

    // clock and reset
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // block ports; the inputs are all known from time zero
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     out_data;
    logic        cfg_write_en = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_LENGTH;
    logic [63:0] cfg_data = '0;

    // checker feedback
    int          failures;
    int          pending;

    // stimulus state
    logic [7:0]  body_bytes [$];
    logic [7:0]  key_chars [KEY_BYTES];
    logic [7:0]  blank_chars [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
    logic [7:0]  pick;
    logic [3:0]  key_len_cfg;
    logic [63:0] key_low_cfg;
    logic [47:0] key_high_cfg;
    int          key_span;
    int          bytes_sent = 0;
    int          body_count = 0;
    int          cycle_count = 0;
    bit          tx_fast = 1'b0;      // sender runs with no gaps for this body
    bit          rx_fast = 1'b0;      // receiver takes results with no stalls
    int          hold_requests = 0;   // bumped to ask the receiver for a long hold-off
    int          holds_granted = 0;
    int          wait_left = 0;

    always #10 clk = ~clk;

    json_string_field_extractor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    json_string_field_extractor_checker scan_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .pending      (pending)
    );

    // watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("json_string_field_extractor regression: fail");
            $finish;
        end
    end

    // result side: after each transfer draw a random stall, possibly none,
    // or hold off for a long stretch when the stimulus asks for it
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_granted != hold_requests)
            begin
                holds_granted = hold_requests;
                wait_left     = LONG_HOLD;
            end
            else if (out_valid && !out_stall)
            begin
                // now and then switch between stall-free stretches and random stalls
                if ($urandom_range(0, 31) == 0)
                    rx_fast = ($urandom_range(0, 3) == 0);
                wait_left = rx_fast ? 0 : $urandom_range(0, 15);
            end
            @(negedge clk);
            if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // append one byte to the body under construction
    task automatic add_body_byte(input logic [7:0] b);
        body_bytes = {body_bytes, b};
    endtask

    // send body_bytes, end_of_body on the last one; called and left at a falling
    // edge, with in_valid still high so that back-to-back transfers need no toggle
    task automatic send_body();
        in_item_t item;
        int       gap;
        for (int i = 0; i < body_bytes.size(); i++)
        begin
            item.in_byte     = body_bytes[i];
            item.end_of_body = (i == body_bytes.size() - 1);
            gap = (tx_fast || $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            @(negedge clk);
            bytes_sent++;
        end
    endtask

    // stop offering, drain every expected result, then let the pipe settle
    task automatic quiesce();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // three back-to-back register writes while the block is idle
    task automatic load_key(input logic [3:0] len, input logic [63:0] low,
                            input logic [47:0] high);
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_KEY_LENGTH;
        cfg_data     <= {60'd0, len};
        @(negedge clk);
        cfg_index    <= CFG_KEY_LOW;
        cfg_data     <= low;
        @(negedge clk);
        cfg_index    <= CFG_KEY_HIGH;
        cfg_data     <= {16'd0, high};
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // a body holding "key" : "value" with random filler; with faults set it may
    // break the opening quote, drop the closing quote or cut the body short
    task automatic compose_field(input int value_len, input bit faults);
        int cut;
        body_bytes.delete();
        repeat ($urandom_range(0, 5))
        begin
            pick = 8'($urandom_range(0, 255));
            add_body_byte(pick);
        end
        add_body_byte(CH_QUOTE);
        for (int i = 0; i < key_span; i++)
            add_body_byte(key_chars[i]);
        add_body_byte(CH_QUOTE);
        // filler between key and colon
        repeat ($urandom_range(0, 2))
        begin
            pick = 8'($urandom_range(0, 255));
            if (pick == CH_COLON)
                pick = CH_SPACE;
            add_body_byte(pick);
        end
        add_body_byte(CH_COLON);
        repeat ($urandom_range(0, 3))
            add_body_byte(blank_chars[2'($urandom_range(0, 3))]);
        if (faults && $urandom_range(0, 9) == 0)
        begin
            // anything but a quote or a blank where the value should open
            do
                pick = 8'($urandom_range(0, 255));
            while (pick == CH_QUOTE || pick == CH_SPACE || pick == CH_TAB ||
                   pick == CH_LF || pick == CH_CR);
            add_body_byte(pick);
        end
        else
            add_body_byte(CH_QUOTE);
        repeat (value_len)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_body_byte(CH_BACKSLASH);
                case ($urandom_range(0, 3))
                    0:       pick = CH_N;
                    1:       pick = CH_R;
                    2:       pick = CH_T;
                    default: pick = 8'($urandom_range(0, 255));
                endcase
            end
            else
            begin
                do
                    pick = 8'($urandom_range(0, 255));
                while (pick == CH_QUOTE || pick == CH_BACKSLASH);
            end
            add_body_byte(pick);
        end
        if (!faults || $urandom_range(0, 9) != 0)
            add_body_byte(CH_QUOTE);
        if (faults)
        begin
            // trailing bytes after the value, ignored once a verdict is out
            repeat ($urandom_range(0, 3))
            begin
                pick = 8'($urandom_range(0, 255));
                add_body_byte(pick);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, body_bytes.size());
                while (body_bytes.size() > cut)
                    void'(body_bytes.pop_back());
            end
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty key, so the needle is just two quotes
        load_key(4'd0, {$urandom, $urandom}, {16'($urandom), $urandom});
        // all escapes, an escaped quote, extreme value bytes, then completion
        body_bytes = {CH_QUOTE, CH_QUOTE, CH_COLON, CH_SPACE, CH_QUOTE,
                      CH_BACKSLASH, CH_N, CH_BACKSLASH, CH_R, CH_BACKSLASH, CH_T,
                      CH_BACKSLASH, CH_QUOTE, 8'hFF, 8'h00, CH_QUOTE};
        send_body();
        // a non-quote after the blanks, then a byte after the verdict
        body_bytes = {CH_QUOTE, CH_QUOTE, CH_COLON, CH_TAB, 8'h78, 8'h79};
        send_body();
        // one-byte body: not found on its only byte
        body_bytes.delete();
        add_body_byte(8'h00);
        send_body();
        // body ends inside the value: the last value byte is dropped
        body_bytes = {CH_QUOTE, CH_QUOTE, CH_COLON, CH_LF, CH_CR, CH_QUOTE,
                      8'h61, 8'h62};
        send_body();

        // random part: new key every few bodies, extremes of key length among them
        while (bytes_sent < TARGET_BYTES)
        begin
            if (body_count % BODIES_PER_KEY == 0)
            begin
                quiesce();
                case ((body_count / BODIES_PER_KEY) % 5)
                    0:       key_len_cfg = 4'd15;   // clipped to the longest key
                    1:       key_len_cfg = 4'd0;
                    2:       key_len_cfg = 4'd14;
                    default: key_len_cfg = 4'($urandom_range(1, 13));
                endcase
                key_span = (key_len_cfg > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(key_len_cfg);
                for (int i = 0; i < KEY_BYTES; i++)
                begin
                    if ((body_count / BODIES_PER_KEY) % 5 == 2)
                        key_chars[i] = 8'hFF;
                    else if ($urandom_range(0, 3) == 0)
                        key_chars[i] = 8'($urandom_range(0, 255));
                    else
                        key_chars[i] = 8'h61 + 8'($urandom_range(0, 25));
                    if (i < 8)
                        key_low_cfg[8*i +: 8] = key_chars[i];
                    else
                        key_high_cfg[8*(i-8) +: 8] = key_chars[i];
                end
                load_key(key_len_cfg, key_low_cfg, key_high_cfg);
            end
            if (body_count == 1)
            begin
                // receiver holds off while a long value streams in at full rate
                hold_requests++;
                tx_fast = 1'b1;
                compose_field(40, 1'b0);
            end
            else
            begin
                tx_fast = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 4) == 0)
                begin
                    // noise body
                    body_bytes.delete();
                    repeat ($urandom_range(1, 12))
                    begin
                        pick = 8'($urandom_range(0, 255));
                        add_body_byte(pick);
                    end
                end
                else
                    compose_field(($urandom_range(0, 9) == 0) ? 12 : $urandom_range(0, 8),
                                  1'b1);
            end
            send_body();
            body_count++;
        end

        quiesce();
        if (failures == 0)
            $display("json_string_field_extractor regression: pass");
        else
            $display("json_string_field_extractor regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/jsfe_pkg.sv
rtl/jsfe_key_match.sv
rtl/jsfe_parse.sv
rtl/jsfe_out_buf.sv
rtl/json_string_field_extractor.sv
tb/sv/json_string_field_extractor_checker.sv
tb/sv/json_string_field_extractor_tb.sv
